### sv/spp_pkg.sv
// Shared types, constants and the gain scaling function of the spike pattern player.
// No dependencies; every other file of the block except spp_ram imports this package.
package spp_pkg;

  // Pattern store geometry and slot timing
  localparam int PATTERN_DEPTH  = 1024;
  localparam int TICKS_PER_SLOT = 4;
  localparam int ADDR_W         = $clog2(PATTERN_DEPTH);
  localparam int SUB_W          = (TICKS_PER_SLOT > 1) ? $clog2(TICKS_PER_SLOT) : 1;

  // Field widths
  localparam int OP_W    = 2;
  localparam int INDEX_W = 10;
  localparam int LEVEL_W = 8;
  localparam int GAIN_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Regulator arithmetic: error is 9 bits signed, scaled terms fit in 14 bits signed
  localparam int ERR_W  = LEVEL_W + 1;
  localparam int PROD_W = ERR_W + GAIN_W + 1;
  localparam int WIDE_W = 14;
  localparam int INTEG_W = 10;

  localparam logic signed [WIDE_W-1:0] INT_LOW  = -14'sd100;
  localparam logic signed [WIDE_W-1:0] INT_HIGH = 14'sd255;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_TICK   = 2'd2,
    OP_SAMPLE = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT    = 3'd0,
    REG_LAST_INDEX  = 3'd1,
    REG_PULSE_TICKS = 3'd2,
    REG_PROP_GAIN   = 3'd3,
    REG_INT_GAIN    = 3'd4,
    REG_OUT_MIN     = 3'd5,
    REG_OUT_MAX     = 3'd6
  } cfg_reg_t;

  // Map a pattern index onto a store address (modulo the store depth)
  function automatic logic [ADDR_W-1:0] addr_of(input logic [INDEX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[ADDR_W-1:0];
  endfunction

  // err * gain / 256, Q4.8 gain, truncated toward zero
  function automatic logic signed [WIDE_W-1:0] scale_q48(
    input logic signed [ERR_W-1:0] err,
    input logic [GAIN_W-1:0]       gain
  );
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] shifted;
    prod = err * $signed({1'b0, gain});
    if (prod < 0) begin
      prod = prod + PROD_W'(255);
    end
    shifted = prod >>> 8;
    return shifted[WIDE_W-1:0];
  endfunction

endpackage

### sv/spp_item_if.sv
// Input item channel of the spike pattern player: valid/ready plus item fields.
// Depends on spp_pkg for field widths.
interface spp_item_if import spp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [INDEX_W-1:0]   pattern_addr;
  logic                 pattern_bit;
  logic [LEVEL_W-1:0]   current_sample;
  logic                 use_pot;
  logic [LEVEL_W-1:0]   pot_setpoint;

  modport source (output valid, opcode, pattern_addr, pattern_bit, current_sample,
                  use_pot, pot_setpoint, input ready);
  modport sink   (input valid, opcode, pattern_addr, pattern_bit, current_sample,
                  use_pot, pot_setpoint, output ready);
endinterface

### sv/spp_result_if.sv
// Result channel of the spike pattern player: valid/ready plus result fields.
// Depends on spp_pkg for field widths.
interface spp_result_if import spp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [LEVEL_W-1:0]   drive_value;
  logic                 pulse_active;
  logic [INDEX_W-1:0]   play_index;

  modport source (output valid, drive_value, pulse_active, play_index, input ready);
  modport sink   (input valid, drive_value, pulse_active, play_index, output ready);
endinterface

### sv/spp_cfg_if.sv
// Configuration write channel of the spike pattern player: valid/ready, index, data.
// Depends on spp_pkg for field widths.
interface spp_cfg_if import spp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/spp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module spp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### sv/spike_pattern_player_pi_top.sv
// Top level of the spike pattern player with PI current regulation.
// Depends on spp_pkg, the spp_item_if/spp_result_if/spp_cfg_if interfaces and spp_ram.
//
// User notes: the block takes one item per clock while the result side is ready
// and returns exactly one result transaction per item, in order, through the
// stage 1 register and the output register. After reset the pattern store is swept
// to zero, one entry per cycle, so item_in.ready stays low until all PATTERN_DEPTH
// (1024) entries are cleared; configuration writes are taken throughout. Stage 0
// updates the slot counters, writes loads into the pattern RAM, issues the pattern
// read for a slot advance and forms the two scaled regulator terms (one multiplier
// each). Stage 1 owns the pulse countdown, the integral and the held drive, and
// produces the result into an output register; the output register lets a new
// item in while a finished result waits. Throughput while the result side is ready is one
// item per cycle, set by the registered pattern RAM read and the integral update loop.
// Configuration registers must be written only while no item is in flight.
module spike_pattern_player_pi_top import spp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  spp_item_if.sink      item_in,
  spp_result_if.source  result_out,
  spp_cfg_if.sink       cfg
);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  typedef struct packed {
    op_t                       op;
    logic                      adv;
    logic [INDEX_W-1:0]        index;
    logic signed [WIDE_W-1:0]  prop;
    logic signed [WIDE_W-1:0]  iscl;
  } s1_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [LEVEL_W-1:0] setpoint;
  logic [INDEX_W-1:0] last_index;
  logic [LEVEL_W-1:0] pulse_ticks;
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  int_gain;
  logic [LEVEL_W-1:0] out_min;
  logic [LEVEL_W-1:0] out_max;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint    <= '0;
      last_index  <= '0;
      pulse_ticks <= '0;
      prop_gain   <= '0;
      int_gain    <= '0;
      out_min     <= '0;
      out_max     <= '1;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_SETPOINT:    setpoint    <= cfg.data[LEVEL_W-1:0];
        REG_LAST_INDEX:  last_index  <= cfg.data[INDEX_W-1:0];
        REG_PULSE_TICKS: pulse_ticks <= cfg.data[LEVEL_W-1:0];
        REG_PROP_GAIN:   prop_gain   <= cfg.data[GAIN_W-1:0];
        REG_INT_GAIN:    int_gain    <= cfg.data[GAIN_W-1:0];
        REG_OUT_MIN:     out_min     <= cfg.data[LEVEL_W-1:0];
        REG_OUT_MAX:     out_max     <= cfg.data[LEVEL_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing sweep of the pattern store after reset
  // ---------------------------------------------------------------------------
  state_t             state;
  logic [ADDR_W-1:0]  clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(PATTERN_DEPTH - 1)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: ;
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: slot counters, pattern RAM access, scaled regulator terms
  // ---------------------------------------------------------------------------
  logic [INDEX_W-1:0] play_pointer;
  logic [SUB_W-1:0]   sub_tick;

  logic               s1_valid;
  s1_t                s1;
  logic               s1_go;
  logic               out_valid;

  logic               item_acc;
  op_t                op;
  logic [SUB_W:0]     sub_inc;
  logic               wrap;
  logic [INDEX_W-1:0] ptr_adv;
  logic [INDEX_W-1:0] ptr_after;
  logic [LEVEL_W-1:0] sp;
  logic signed [ERR_W-1:0] err;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic               ram_wdata;
  logic               ram_re;
  logic               ram_rdata;

  assign item_in.ready = (state == ST_RUN) && (!s1_valid || s1_go);
  assign item_acc      = item_in.valid && item_in.ready;
  assign op            = op_t'(item_in.opcode);

  assign sub_inc  = {1'b0, sub_tick} + 1'b1;
  assign wrap     = (sub_inc >= (SUB_W + 1)'(TICKS_PER_SLOT));
  assign ptr_adv  = (play_pointer >= last_index) ? '0 : play_pointer + 1'b1;

  always_comb begin
    case (op)
      OP_START: ptr_after = '0;
      OP_TICK:  ptr_after = wrap ? ptr_adv : play_pointer;
      default:  ptr_after = play_pointer;
    endcase
  end

  assign sp  = item_in.use_pot ? item_in.pot_setpoint : setpoint;
  assign err = $signed({1'b0, sp}) - $signed({1'b0, item_in.current_sample});

  always_ff @(posedge clk) begin
    if (rst) begin
      play_pointer <= '0;
      sub_tick     <= '0;
    end else if (item_acc) begin
      case (op)
        OP_START: begin
          play_pointer <= '0;
          sub_tick     <= '0;
        end
        OP_TICK: begin
          play_pointer <= ptr_after;
          sub_tick     <= wrap ? '0 : sub_inc[SUB_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Writes come from the clearing sweep or from load items; reads only on a slot advance
  assign ram_we    = (state == ST_CLEAR) || (item_acc && op == OP_LOAD);
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : addr_of(item_in.pattern_addr);
  assign ram_wdata = (state == ST_CLEAR) ? 1'b0 : item_in.pattern_bit;
  assign ram_re    = item_acc && (op == OP_TICK) && wrap;

  spp_ram #(
    .WIDTH (1),
    .DEPTH (PATTERN_DEPTH)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_of(ptr_adv)),
    .rdata (ram_rdata)
  );

  // Stage 1 register: the RAM output register holds the pattern bit alongside
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      s1.op    <= op;
      s1.adv   <= (op == OP_TICK) && wrap;
      s1.index <= ptr_after;
      s1.prop  <= scale_q48(err, prop_gain);
      s1.iscl  <= scale_q48(err, int_gain);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pulse countdown, PI update, result formation
  // ---------------------------------------------------------------------------
  logic [LEVEL_W-1:0]        pulse_left;
  logic signed [INTEG_W-1:0] integral_term;
  logic [LEVEL_W-1:0]        drive_hold;

  logic [LEVEL_W-1:0]        pulse_left_next;
  logic signed [INTEG_W-1:0] integral_term_next;
  logic [LEVEL_W-1:0]        drive_hold_next;
  logic signed [WIDE_W-1:0]  isum;
  logic signed [WIDE_W-1:0]  iclamp;
  logic signed [WIDE_W-1:0]  v;

  assign s1_go = s1_valid && (!out_valid || result_out.ready);

  always_comb begin
    isum = WIDE_W'(integral_term) + s1.iscl;
    if (isum < INT_LOW) begin
      iclamp = INT_LOW;
    end else if (isum > INT_HIGH) begin
      iclamp = INT_HIGH;
    end else begin
      iclamp = isum;
    end
    v = s1.prop + iclamp;

    pulse_left_next    = pulse_left;
    integral_term_next = integral_term;
    drive_hold_next    = drive_hold;
    case (s1.op)
      OP_START: pulse_left_next = '0;
      OP_TICK: begin
        if (pulse_left != '0) begin
          pulse_left_next = pulse_left - 1'b1;
        end
        if (s1.adv && ram_rdata) begin
          pulse_left_next = pulse_ticks;
        end
      end
      OP_SAMPLE: begin
        // Regulate only while a pulse is active; out_max is tested first
        if (pulse_left != '0) begin
          integral_term_next = iclamp[INTEG_W-1:0];
          if (v > $signed({{(WIDE_W - LEVEL_W){1'b0}}, out_max})) begin
            drive_hold_next = out_max;
          end else if (v < $signed({{(WIDE_W - LEVEL_W){1'b0}}, out_min})) begin
            drive_hold_next = out_min;
          end else begin
            drive_hold_next = v[LEVEL_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_left    <= '0;
      integral_term <= '0;
      drive_hold    <= '0;
    end else if (s1_go) begin
      pulse_left    <= pulse_left_next;
      integral_term <= integral_term_next;
      drive_hold    <= drive_hold_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      result_out.drive_value  <= (pulse_left_next != '0) ? drive_hold_next : '0;
      result_out.pulse_active <= (pulse_left_next != '0);
      result_out.play_index   <= s1.index;
    end
  end

  assign result_out.valid = out_valid;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_drive_zero_when_idle: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.pulse_active) |-> (result_out.drive_value == '0))
    else $error("drive_value nonzero without an active pulse");

  a_integral_range: assert property (@(posedge clk) disable iff (rst)
    (WIDE_W'(integral_term) >= INT_LOW) && (WIDE_W'(integral_term) <= INT_HIGH))
    else $error("integral term outside its clamp range");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |-> !item_in.ready)
    else $error("input accepted while stage 1 is stalled");

  a_no_read_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!ram_re && !s1_valid))
    else $error("pattern read or item in flight during clearing sweep");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_out.ready) |=> (out_valid && $stable(result_out.play_index)))
    else $error("pending result dropped or changed while stalled");

endmodule
